// File: hdl/hssg_pkg.sv
`default_nettype none
package hssg_pkg;

	localparam int unsigned THRESH_W = 16;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [1:0] ACT_RATIO = 2'd0;
	localparam logic [1:0] ACT_PRIMARY = 2'd1;
	localparam logic [1:0] ACT_FALLBACK = 2'd2;
	localparam logic [1:0] ACT_RESTART = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FALL_SAMPLES = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RISE_SAMPLES = 2'd3;

	localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RESET = 16'd9830;
	localparam logic [THRESH_W-1:0] HIGH_THRESHOLD_RESET = 16'd16384;
	localparam logic [COUNT_W-1:0] FALL_SAMPLES_RESET = 8'd3;
	localparam logic [COUNT_W-1:0] RISE_SAMPLES_RESET = 8'd3;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic OWNER_PRIMARY = 1'b0;
	localparam logic OWNER_FALLBACK = 1'b1;

	typedef struct packed {
		logic [1:0] action;
		logic [THRESH_W-1:0] ratio;
		logic [CHAR_W-1:0] text_char;
		logic chunk_end;
	} in_item_t;

	typedef struct packed {
		logic out_valid;
		logic [CHAR_W-1:0] out_char;
		logic from_fallback;
		logic owner_changed;
		logic current_owner;
	} out_item_t;

endpackage
`default_nettype wire

// File: hdl/hssg_stream_if.sv
`default_nettype none
interface hssg_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/hysteresis_source_switch_at_gap.sv
`default_nettype none
// Arbiter between a primary and a fallback Morse text decoder.
// The items channel carries one action per item: a keying-ratio sample,
// a character from either decoder, or a restart. The results channel
// returns exactly one result per item, in order, telling whether the
// character was forwarded, from which decoder, and who owns the output.
// An accepted item is held in the input stage and its result is loaded
// into the output register when that register is free, from where it
// can be taken. The whole update is a few compares and an 8-bit counter
// step, so one item is accepted every cycle when the receiver keeps up.
// When the receiver stalls, the output register holds its result; one
// more item may enter the input stage, after which ready drops until the
// result is taken.
// Reset returns the thresholds and run lengths to their defaults and
// clears the arbitration state. The user must write configuration via the
// plain write port only while no item is in flight, unchecked by the block.
module hysteresis_source_switch_at_gap (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [hssg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [hssg_pkg::CFG_DATA_W-1:0] cfg_data,
	hssg_stream_if.sink items,
	hssg_stream_if.source results
);
	import hssg_pkg::*;

	logic [THRESH_W-1:0] low_threshold_q;
	logic [THRESH_W-1:0] high_threshold_q;
	logic [COUNT_W-1:0] fall_samples_q;
	logic [COUNT_W-1:0] rise_samples_q;

	logic owner_q, desired_q, seeded_q, gap_seen_q;
	logic [COUNT_W-1:0] fade_run_q, solid_run_q;

	logic valid_s1;
	in_item_t item_s1;
	logic valid_s2;
	out_item_t res_s2;

	logic advance;
	logic owner_d, desired_d, seeded_d, gap_seen_d;
	logic [COUNT_W-1:0] fade_run_d, solid_run_d;
	out_item_t res_d;
	logic is_low, is_high, src;

	assign advance = !valid_s2 || results.ready;
	assign items.ready = !valid_s1 || advance;
	assign results.valid = valid_s2;
	assign results.payload = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_threshold_q <= LOW_THRESHOLD_RESET;
			high_threshold_q <= HIGH_THRESHOLD_RESET;
			fall_samples_q <= FALL_SAMPLES_RESET;
			rise_samples_q <= RISE_SAMPLES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_THRESHOLD: low_threshold_q <= cfg_data;
				REG_HIGH_THRESHOLD: high_threshold_q <= cfg_data;
				REG_FALL_SAMPLES: fall_samples_q <= cfg_data[COUNT_W-1:0];
				REG_RISE_SAMPLES: rise_samples_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		owner_d = owner_q;
		desired_d = desired_q;
		seeded_d = seeded_q;
		gap_seen_d = gap_seen_q;
		fade_run_d = fade_run_q;
		solid_run_d = solid_run_q;
		res_d = '0;
		is_low = item_s1.ratio < low_threshold_q;
		is_high = item_s1.ratio > high_threshold_q;
		src = (item_s1.action == ACT_FALLBACK);
		case (item_s1.action)
			ACT_RATIO: begin
				if (!seeded_q) begin
					seeded_d = 1'b1;
					owner_d = is_low ? OWNER_FALLBACK : OWNER_PRIMARY;
					desired_d = owner_d;
					if (owner_d != owner_q) begin
						res_d.owner_changed = 1'b1;
						gap_seen_d = 1'b0;
					end
				end
				if (is_low) begin
					solid_run_d = '0;
					if (fade_run_q != COUNT_MAX) begin
						fade_run_d = fade_run_q + 1'b1;
					end
					if (fade_run_d >= fall_samples_q) begin
						desired_d = OWNER_FALLBACK;
					end
				end else if (is_high) begin
					fade_run_d = '0;
					if (solid_run_q != COUNT_MAX) begin
						solid_run_d = solid_run_q + 1'b1;
					end
					if (solid_run_d >= rise_samples_q) begin
						desired_d = OWNER_PRIMARY;
					end
				end
			end
			ACT_PRIMARY, ACT_FALLBACK: begin
				if (src == owner_q) begin
					res_d.out_valid = 1'b1;
					res_d.out_char = item_s1.text_char;
					res_d.from_fallback = src;
					if (item_s1.text_char == SPACE_CHAR) begin
						gap_seen_d = 1'b1;
					end
					if (item_s1.chunk_end) begin
						if (gap_seen_d && (desired_q != owner_q)) begin
							owner_d = desired_q;
							res_d.owner_changed = 1'b1;
						end
						gap_seen_d = 1'b0;
					end
				end
			end
			default: begin
				owner_d = OWNER_PRIMARY;
				desired_d = OWNER_PRIMARY;
				seeded_d = 1'b0;
				gap_seen_d = 1'b0;
				fade_run_d = '0;
				solid_run_d = '0;
			end
		endcase
		res_d.current_owner = owner_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			owner_q <= OWNER_PRIMARY;
			desired_q <= OWNER_PRIMARY;
			seeded_q <= 1'b0;
			gap_seen_q <= 1'b0;
			fade_run_q <= '0;
			solid_run_q <= '0;
		end else begin
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				owner_q <= owner_d;
				desired_q <= desired_d;
				seeded_q <= seeded_d;
				gap_seen_q <= gap_seen_d;
				fade_run_q <= fade_run_d;
				solid_run_q <= solid_run_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.payload;
		end
		if (advance && valid_s1) begin
			res_s2 <= res_d;
		end
	end

`ifndef SYNTH
	a_forward_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.out_valid && !res_s2.owner_changed
		|-> res_s2.from_fallback == res_s2.current_owner)
		else $error("forwarded item does not match the owner");

	a_muted_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.out_valid |-> res_s2.out_char == '0 && !res_s2.from_fallback)
		else $error("dropped item carries a character");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(owner_q) && $stable(desired_q)
		&& $stable(fade_run_q) && $stable(solid_run_q))
		else $error("arbitration state moved without an item");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> valid_s1 && valid_s2 && !results.ready)
		else $error("input stalled while the pipeline has room");

	a_owner_report: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 |=> res_s2.current_owner == owner_q)
		else $error("reported owner differs from the stored owner");
`endif

endmodule
`default_nettype wire

// File: sim/hysteresis_source_switch_at_gap_test.sv
module hysteresis_source_switch_at_gap_test;
	import hssg_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASES = 8;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hssg_stream_if #(.T(in_item_t)) items_if ();
	hssg_stream_if #(.T(out_item_t)) results_if ();

	hysteresis_source_switch_at_gap dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.items(items_if),
		.results(results_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [THRESH_W-1:0] low_thr;
	logic [THRESH_W-1:0] high_thr;
	logic [COUNT_W-1:0] fall_len;
	logic [COUNT_W-1:0] rise_len;

	logic arb_owner;
	logic arb_desired;
	logic [COUNT_W-1:0] fade_count;
	logic [COUNT_W-1:0] solid_count;
	logic arb_seeded;
	logic arb_gap;

	in_item_t pending_items[$];
	out_item_t expected_decisions[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	function automatic void clear_arbitration();
		arb_owner = OWNER_PRIMARY;
		arb_desired = OWNER_PRIMARY;
		fade_count = '0;
		solid_count = '0;
		arb_seeded = 1'b0;
		arb_gap = 1'b0;
	endfunction

	function automatic out_item_t predict_arbitration(input in_item_t it);
		out_item_t res;
		logic faded;
		logic pick;
		logic src;
		res = '0;
		case (it.action)
		ACT_RATIO: begin
			faded = (it.ratio < low_thr);
			if (!arb_seeded) begin
				pick = faded ? OWNER_FALLBACK : OWNER_PRIMARY;
				arb_seeded = 1'b1;
				if (pick != arb_owner) begin
					res.owner_changed = 1'b1;
					arb_gap = 1'b0;
				end
				arb_owner = pick;
				arb_desired = pick;
			end
			if (faded) begin
				solid_count = '0;
				if (fade_count != COUNT_MAX)
					fade_count = fade_count + 1'b1;
				if (fade_count >= fall_len)
					arb_desired = OWNER_FALLBACK;
			end else if (it.ratio > high_thr) begin
				fade_count = '0;
				if (solid_count != COUNT_MAX)
					solid_count = solid_count + 1'b1;
				if (solid_count >= rise_len)
					arb_desired = OWNER_PRIMARY;
			end
		end
		ACT_RESTART: clear_arbitration();
		default: begin
			src = (it.action == ACT_FALLBACK) ? OWNER_FALLBACK : OWNER_PRIMARY;
			if (src == arb_owner) begin
				res.out_valid = 1'b1;
				res.out_char = it.text_char;
				res.from_fallback = src;
				if (it.text_char == SPACE_CHAR)
					arb_gap = 1'b1;
				if (it.chunk_end) begin
					if (arb_gap && arb_desired != arb_owner) begin
						arb_owner = arb_desired;
						res.owner_changed = 1'b1;
					end
					arb_gap = 1'b0;
				end
			end
		end
		endcase
		res.current_owner = arb_owner;
		return res;
	endfunction

	function automatic in_item_t make_item(input logic [1:0] action,
			input logic [THRESH_W-1:0] ratio, input logic [CHAR_W-1:0] ch,
			input logic ends);
		in_item_t it;
		it.action = action;
		it.ratio = ratio;
		it.text_char = ch;
		it.chunk_end = ends;
		return it;
	endfunction

	function automatic logic [THRESH_W-1:0] pick_ratio(input int unsigned kind);
		case (kind)
		0: return (low_thr == 0) ? 16'd0 : 16'($urandom_range(0, low_thr - 1));
		1: return (high_thr == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(high_thr + 1, 65535));
		2: return 16'($urandom_range(low_thr, high_thr));
		3: begin
			case ($urandom_range(0, 3))
			0: return low_thr;
			1: return high_thr;
			2: return 16'd0;
			default: return 16'hFFFF;
			endcase
		end
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_ratio_run(input int unsigned len, input int unsigned kind);
		int unsigned i;
		int unsigned k;
		for (i = 0; i < len; i++) begin
			k = ($urandom_range(0, 9) == 0) ? 2 : kind;
			pending_items.push_back(make_item(ACT_RATIO, pick_ratio(k), 8'($urandom),
				1'($urandom)));
		end
	endtask

	task automatic add_chunk(input int unsigned len, input logic [1:0] action);
		int unsigned i;
		logic [CHAR_W-1:0] ch;
		for (i = 0; i < len; i++) begin
			ch = ($urandom_range(0, 99) < 30) ? SPACE_CHAR : 8'($urandom);
			pending_items.push_back(make_item(action, 16'($urandom), ch, i == len - 1));
		end
	endtask

	task automatic add_traffic(input int unsigned count);
		int unsigned added;
		int unsigned roll;
		int unsigned len;
		added = 0;
		while (added < count) begin
			roll = $urandom_range(0, 99);
			len = $urandom_range(1, 6);
			if (roll < 40) begin
				add_ratio_run(len, $urandom_range(0, 4));
				added += len;
			end else if (roll < 85) begin
				add_chunk(len, $urandom_range(0, 1) ? ACT_FALLBACK : ACT_PRIMARY);
				added += len;
			end else if (roll < 90) begin
				pending_items.push_back(make_item(ACT_RESTART, 16'($urandom), 8'($urandom),
					1'($urandom)));
				added++;
			end else begin
				pending_items.push_back(make_item(2'($urandom), 16'($urandom), 8'($urandom),
					1'($urandom)));
				added++;
			end
		end
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
		REG_LOW_THRESHOLD: low_thr = data;
		REG_HIGH_THRESHOLD: high_thr = data;
		REG_FALL_SAMPLES: fall_len = data[COUNT_W-1:0];
		default: rise_len = data[COUNT_W-1:0];
		endcase
	endtask

	task automatic set_registers(input logic [THRESH_W-1:0] lo, input logic [THRESH_W-1:0] hi,
			input logic [COUNT_W-1:0] fall, input logic [COUNT_W-1:0] rise);
		write_register(REG_LOW_THRESHOLD, lo);
		write_register(REG_HIGH_THRESHOLD, hi);
		write_register(REG_FALL_SAMPLES, CFG_DATA_W'(fall));
		write_register(REG_RISE_SAMPLES, CFG_DATA_W'(rise));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_for_drain();
		while (pending_items.size() != 0 || items_if.valid || expected_decisions.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (items_if.valid && items_if.ready)
				expected_decisions.push_back(predict_arbitration(items_if.payload));
			if (!items_if.valid || items_if.ready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					items_if.payload <= pending_items.pop_front();
					items_if.valid <= 1'b1;
				end else begin
					items_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			results_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (results_if.valid && results_if.ready) begin
				got = results_if.payload;
				if (expected_decisions.size() == 0) begin
					$error("result with no item outstanding: out_char expected none, actual %0d",
						got.out_char);
					mismatches++;
				end else begin
					want = expected_decisions.pop_front();
					check_field("out_valid", want.out_valid, got.out_valid);
					check_field("out_char", want.out_char, got.out_char);
					check_field("from_fallback", want.from_fallback, got.from_fallback);
					check_field("owner_changed", want.owner_changed, got.owner_changed);
					check_field("current_owner", want.current_owner, got.current_owner);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("hysteresis_source_switch_at_gap regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned phase;
		int unsigned lo;
		int unsigned random_items[PHASES];
		random_items = '{40, 25, 25, 40, 40, 10, 50, 50};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LOW_THRESHOLD;
		cfg_data = '0;
		items_if.valid = 1'b0;
		items_if.payload = '0;
		results_if.ready = 1'b0;
		low_thr = LOW_THRESHOLD_RESET;
		high_thr = HIGH_THRESHOLD_RESET;
		fall_len = FALL_SAMPLES_RESET;
		rise_len = RISE_SAMPLES_RESET;
		clear_arbitration();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: ;
			1: set_registers(16'd0, 16'hFFFF, 8'd0, 8'd0);
			2: set_registers(16'hFFFF, 16'd0, 8'd1, 8'd1);
			3: set_registers(16'd20000, 16'd30000, 8'd2, 8'd4);
			4: set_registers(LOW_THRESHOLD_RESET, HIGH_THRESHOLD_RESET, 8'd0, 8'd0);
			5: set_registers(16'd32768, 16'd32768, COUNT_MAX, COUNT_MAX);
			6: begin
				lo = $urandom_range(0, 32767);
				set_registers(16'(lo), 16'($urandom_range(lo, 65535)),
					8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
			end
			default: set_registers(16'($urandom), 16'($urandom),
				8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)));
			endcase

			case (phase % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 61;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 61;
			end
			default: begin
				send_idle_pct = 24;
				recv_stall_pct = 24;
			end
			endcase

			@(negedge clk);
			case (phase)
			0: begin
				pending_items.push_back(make_item(ACT_PRIMARY, 16'd0, 8'h41, 1'b0));
				pending_items.push_back(make_item(ACT_FALLBACK, 16'd0, 8'h42, 1'b1));
				pending_items.push_back(make_item(ACT_RATIO, 16'd0, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_FALLBACK, 16'd0, 8'hFF, 1'b0));
				pending_items.push_back(make_item(ACT_FALLBACK, 16'd0, SPACE_CHAR, 1'b0));
				pending_items.push_back(make_item(ACT_RATIO, 16'hFFFF, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_RATIO, 16'hFFFF, 8'hFF, 1'b1));
				pending_items.push_back(make_item(ACT_RATIO, HIGH_THRESHOLD_RESET, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_RATIO, HIGH_THRESHOLD_RESET + 1'b1, 8'd0,
					1'b0));
				pending_items.push_back(make_item(ACT_PRIMARY, 16'hFFFF, 8'h78, 1'b1));
				pending_items.push_back(make_item(ACT_FALLBACK, 16'hFFFF, 8'h00, 1'b1));
				pending_items.push_back(make_item(ACT_RATIO, LOW_THRESHOLD_RESET - 1'b1, 8'd0,
					1'b0));
				pending_items.push_back(make_item(ACT_RATIO, LOW_THRESHOLD_RESET, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_RATIO, LOW_THRESHOLD_RESET - 1'b1, 8'd0,
					1'b0));
				pending_items.push_back(make_item(ACT_RATIO, 16'd0, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_PRIMARY, 16'd0, 8'h61, 1'b1));
				pending_items.push_back(make_item(ACT_PRIMARY, 16'd0, SPACE_CHAR, 1'b1));
				pending_items.push_back(make_item(ACT_FALLBACK, 16'd0, SPACE_CHAR, 1'b1));
				pending_items.push_back(make_item(ACT_RESTART, 16'd0, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_RATIO, LOW_THRESHOLD_RESET, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_FALLBACK, 16'd0, SPACE_CHAR, 1'b1));
				pending_items.push_back(make_item(ACT_RESTART, 16'hFFFF, 8'hFF, 1'b1));
				pending_items.push_back(make_item(ACT_PRIMARY, 16'hFFFF, SPACE_CHAR, 1'b1));
			end
			4: begin
				pending_items.push_back(make_item(ACT_RESTART, 16'd0, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_RATIO, 16'hFFFF, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_RATIO, 16'd0, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_PRIMARY, 16'd0, SPACE_CHAR, 1'b1));
				pending_items.push_back(make_item(ACT_RATIO, 16'hFFFF, 8'd0, 1'b0));
				pending_items.push_back(make_item(ACT_FALLBACK, 16'd0, SPACE_CHAR, 1'b1));
			end
			5: begin
				add_ratio_run(258, 0);
				add_chunk(4, ACT_PRIMARY);
				add_chunk(4, ACT_FALLBACK);
				add_ratio_run(258, 1);
				add_chunk(4, ACT_FALLBACK);
				add_chunk(4, ACT_PRIMARY);
			end
			default: ;
			endcase
			add_traffic(random_items[phase]);
			wait_for_drain();
		end

		if (mismatches == 0)
			$display("hysteresis_source_switch_at_gap regression: pass");
		else
			$display("hysteresis_source_switch_at_gap regression: fail");
		$finish;
	end

endmodule
